/* rtl/core/hsc_pkg.sv */
// shared types, constants and helper functions of the host name syntax checker
package hsc_pkg;

  localparam int unsigned HSC_QDEPTH = 2;
  localparam int unsigned HSC_QPTR_W = (HSC_QDEPTH > 1) ? $clog2(HSC_QDEPTH) : 1;
  localparam int unsigned HSC_QCNT_W = $clog2(HSC_QDEPTH + 1);

  localparam int unsigned HSC_CHAR_W = 8;
  localparam int unsigned HSC_CFG_W  = 8;
  localparam int unsigned HSC_CNT_W  = 9;
  localparam int unsigned HSC_STAT_W = 4;

  localparam logic [HSC_CNT_W-1:0] HSC_SAT_MAX       = 9'd256;
  localparam logic [HSC_CFG_W-1:0] HSC_MAX_NAME_RST  = 8'd253;
  localparam logic [HSC_CFG_W-1:0] HSC_MAX_LABEL_RST = 8'd63;

  typedef enum logic [0:0] {
    REG_MAX_NAME  = 1'b0,
    REG_MAX_LABEL = 1'b1
  } cfg_idx_e;

  typedef enum logic [HSC_STAT_W-1:0] {
    ST_VALID       = 4'd0,
    ST_EMPTY       = 4'd1,
    ST_TOO_LONG    = 4'd2,
    ST_LEAD_DOT    = 4'd3,
    ST_TRAIL_DOT   = 4'd4,
    ST_DOUBLE_DOT  = 4'd5,
    ST_EMPTY_LABEL = 4'd6,
    ST_LABEL_LONG  = 4'd7,
    ST_BAD_CHARS   = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_DOT,
    CLS_ALNUM,
    CLS_HYPHEN,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic has;
    logic last;
    cls_e cls;
  } tok_t;

  typedef struct packed {
    logic [HSC_CFG_W-1:0] max_name;
    logic [HSC_CFG_W-1:0] max_label;
  } cfg_t;

  typedef struct packed {
    status_e              status;
    logic                 is_valid;
    logic [HSC_CNT_W-1:0] length;
  } res_t;

  typedef struct packed {
    logic                 seen;
    logic [HSC_CNT_W-1:0] total;
    logic [HSC_CNT_W-1:0] pend;
    logic                 fdot;
    logic                 pdot;
    logic                 ddot;
    logic [HSC_CNT_W-1:0] lcnt;
    logic                 lgood;
    logic                 lalnum;
    status_e              fault;
  } name_st_t;

  localparam name_st_t HSC_ST_CLEAR = '{
    seen:   1'b0,
    total:  '0,
    pend:   '0,
    fdot:   1'b0,
    pdot:   1'b0,
    ddot:   1'b0,
    lcnt:   '0,
    lgood:  1'b1,
    lalnum: 1'b0,
    fault:  ST_VALID
  };

  function automatic logic [HSC_CNT_W-1:0] sat_add(input logic [HSC_CNT_W-1:0] a,
                                                   input logic [HSC_CNT_W-1:0] b);
    logic [HSC_CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, HSC_SAT_MAX}) ? HSC_SAT_MAX : s[HSC_CNT_W-1:0];
  endfunction

  // verdict of one label as it closes
  function automatic status_e label_fault(input logic [HSC_CNT_W-1:0] lcnt,
                                          input logic [HSC_CFG_W-1:0] max_label,
                                          input logic                 lgood,
                                          input logic                 lalnum);
    status_e f;
    if (lcnt == '0) begin
      f = ST_EMPTY_LABEL;
    end else if (lcnt > {1'b0, max_label}) begin
      f = ST_LABEL_LONG;
    end else if (!lgood || !lalnum) begin
      f = ST_BAD_CHARS;
    end else begin
      f = ST_VALID;
    end
    return f;
  endfunction

endpackage

/* rtl/core/hsc_if.sv */
// request channel interfaces for characters in and verdicts out
interface hsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [hsc_pkg::HSC_CHAR_W-1:0] char_code;
  logic                         has_char;
  logic                         is_last;

  modport source (output valid, output char_code, output has_char, output is_last,
                  input ready);
  modport sink (input valid, input char_code, input has_char, input is_last,
                output ready);
endinterface

interface hsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [hsc_pkg::HSC_STAT_W-1:0] status;
  logic                          is_valid;
  logic [hsc_pkg::HSC_CNT_W-1:0]  trimmed_length;

  modport source (output valid, output status, output is_valid, output trimmed_length,
                  input ready);
  modport sink (input valid, input status, input is_valid, input trimmed_length,
                output ready);
endinterface

/* rtl/core/hostname_syntax_checker_core.sv */
// top level of the streaming host name syntax checker
// Takes a host name one Latin-1 character per request on in_i (has_char 0 is a
// bare marker, is_last 1 closes the name) and returns one verdict per name on
// out_o: status code, is_valid and the length after whitespace trimming. Every
// accepted request is one state update in the back end, so with out_o ready the
// block sustains one character per clock; a verdict passes the token queue and the
// output register before it appears on out_o. The pace is set by the back end's
// state update; the two-entry token queue and the output register let in_i keep
// flowing while a verdict waits. The user must write limits through cfg_we_i /
// cfg_idx_i / cfg_wdata_i only while idle; the block itself does not enforce it.
module hostname_syntax_checker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [hsc_pkg::HSC_CFG_W-1:0] cfg_wdata_i,
  hsc_in_if.sink                        in_i,
  hsc_out_if.source                     out_o
);

  hsc_pkg::cfg_t cfg_q, cfg_d;
  hsc_pkg::tok_t push_tok, pop_tok;
  hsc_pkg::res_t res;
  logic          push, full, pop_valid, pop_ready, res_valid;

  // limit registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (hsc_pkg::cfg_idx_e'(cfg_idx_i))
        hsc_pkg::REG_MAX_NAME:  cfg_d.max_name  = cfg_wdata_i;
        hsc_pkg::REG_MAX_LABEL: cfg_d.max_label = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_name  <= hsc_pkg::HSC_MAX_NAME_RST;
      cfg_q.max_label <= hsc_pkg::HSC_MAX_LABEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify characters
  hsc_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .tok_o  (push_tok)
  );

  // decouple front from back
  hsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_tok),
    .full_o  (full),
    .pop_i   (pop_ready),
    .valid_o (pop_valid),
    .data_o  (pop_tok)
  );

  // running state and verdict
  hsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (pop_valid),
    .tok_i       (pop_tok),
    .tok_ready_o (pop_ready),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  // verdict request
  assign out_o.valid          = res_valid;
  assign out_o.status         = res.status;
  assign out_o.is_valid       = res.is_valid;
  assign out_o.trimmed_length = res.length;

endmodule

/* rtl/core/hsc_front.sv */
// front end: takes a character request and classifies it into a token
module hsc_front (
  hsc_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output hsc_pkg::tok_t tok_o
);

  logic [hsc_pkg::HSC_CHAR_W-1:0] c;
  logic                           is_space;
  logic                           is_alnum;

  assign c = in_i.char_code;

  assign is_space = (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'd133 || c == 8'd160;
  assign is_alnum = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90)
                 || (c >= 8'd97 && c <= 8'd122);

  always_comb begin
    tok_o.has  = in_i.has_char;
    tok_o.last = in_i.is_last;
    if (is_space) begin
      tok_o.cls = hsc_pkg::CLS_SPACE;
    end else if (c == 8'd46) begin
      tok_o.cls = hsc_pkg::CLS_DOT;
    end else if (is_alnum) begin
      tok_o.cls = hsc_pkg::CLS_ALNUM;
    end else if (c == 8'd45) begin
      tok_o.cls = hsc_pkg::CLS_HYPHEN;
    end else begin
      tok_o.cls = hsc_pkg::CLS_OTHER;
    end
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

endmodule

/* rtl/core/hsc_fifo.sv */
// short token queue between front and back
module hsc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hsc_pkg::tok_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hsc_pkg::tok_t data_o
);

  hsc_pkg::tok_t                      mem_q [hsc_pkg::HSC_QDEPTH];
  logic [hsc_pkg::HSC_QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [hsc_pkg::HSC_QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [hsc_pkg::HSC_QCNT_W-1:0]     cnt_q, cnt_d;
  logic                               do_push, do_pop;

  localparam logic [hsc_pkg::HSC_QPTR_W-1:0] PtrLast = hsc_pkg::HSC_QPTR_W'(hsc_pkg::HSC_QDEPTH - 1);
  localparam logic [hsc_pkg::HSC_QCNT_W-1:0] CntFull = hsc_pkg::HSC_QCNT_W'(hsc_pkg::HSC_QDEPTH);

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/hsc_back.sv */
// back end: running name state, verdict and output register
module hsc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  input  hsc_pkg::tok_t tok_i,
  output logic          tok_ready_o,
  input  hsc_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output hsc_pkg::res_t res_o
);

  hsc_pkg::name_st_t st_q, st_d, nx;
  hsc_pkg::res_t     res_q, res_d;
  hsc_pkg::status_e  f_dot, f_end, status;
  logic              res_valid_q, res_valid_d;
  logic              out_free, step, is_alnum;

  assign out_free    = !res_valid_q || res_ready_i;
  assign tok_ready_o = !tok_i.last || out_free;
  assign step        = tok_valid_i && tok_ready_o;
  assign is_alnum    = (tok_i.cls == hsc_pkg::CLS_ALNUM);

  // character update
  always_comb begin
    nx    = st_q;
    f_dot = hsc_pkg::ST_VALID;
    if (tok_i.has) begin
      if (tok_i.cls == hsc_pkg::CLS_SPACE) begin
        if (st_q.seen) begin
          nx.pend = hsc_pkg::sat_add(st_q.pend, 9'd1);
        end
      end else begin
        // inner whitespace becomes bad label characters
        if (st_q.pend != '0) begin
          nx.total  = hsc_pkg::sat_add(st_q.total, st_q.pend);
          nx.lcnt   = hsc_pkg::sat_add(st_q.lcnt, st_q.pend);
          nx.lgood  = 1'b0;
          nx.lalnum = 1'b0;
          nx.pdot   = 1'b0;
          nx.pend   = '0;
        end
        nx.seen = 1'b1;
        if (tok_i.cls == hsc_pkg::CLS_DOT) begin
          if (nx.total == '0) begin
            nx.fdot = 1'b1;
          end
          if (nx.pdot) begin
            nx.ddot = 1'b1;
          end
          nx.total = hsc_pkg::sat_add(nx.total, 9'd1);
          f_dot    = hsc_pkg::label_fault(nx.lcnt, cfg_i.max_label, nx.lgood, nx.lalnum);
          if (nx.fault == hsc_pkg::ST_VALID) begin
            nx.fault = f_dot;
          end
          nx.lcnt   = '0;
          nx.lgood  = 1'b1;
          nx.lalnum = 1'b0;
          nx.pdot   = 1'b1;
        end else begin
          nx.total = hsc_pkg::sat_add(nx.total, 9'd1);
          if (nx.lcnt == '0 && !is_alnum) begin
            nx.lgood = 1'b0;
          end
          if (!is_alnum && tok_i.cls != hsc_pkg::CLS_HYPHEN) begin
            nx.lgood = 1'b0;
          end
          nx.lalnum = is_alnum;
          nx.lcnt   = hsc_pkg::sat_add(nx.lcnt, 9'd1);
          nx.pdot   = 1'b0;
        end
      end
    end
  end

  // verdict at the end of a name
  always_comb begin
    f_end = hsc_pkg::label_fault(nx.lcnt, cfg_i.max_label, nx.lgood, nx.lalnum);
    if (nx.total == '0) begin
      status = hsc_pkg::ST_EMPTY;
    end else if (nx.total > {1'b0, cfg_i.max_name}) begin
      status = hsc_pkg::ST_TOO_LONG;
    end else if (nx.fdot) begin
      status = hsc_pkg::ST_LEAD_DOT;
    end else if (nx.pdot) begin
      status = hsc_pkg::ST_TRAIL_DOT;
    end else if (nx.ddot) begin
      status = hsc_pkg::ST_DOUBLE_DOT;
    end else if (nx.fault != hsc_pkg::ST_VALID) begin
      status = nx.fault;
    end else begin
      status = f_end;
    end
  end

  always_comb begin
    st_d        = st_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    if (step) begin
      st_d = nx;
      if (tok_i.last) begin
        st_d           = hsc_pkg::HSC_ST_CLEAR;
        res_d.status   = status;
        res_d.is_valid = (status == hsc_pkg::ST_VALID);
        res_d.length   = nx.total;
        res_valid_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= hsc_pkg::HSC_ST_CLEAR;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/hsc_checker.sv */
// port-level checker for the host name syntax checker and its bind
module hsc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [hsc_pkg::HSC_STAT_W-1:0] status_i,
  input logic                           is_valid_i,
  input logic [hsc_pkg::HSC_CNT_W-1:0]  trimmed_length_i
);

  localparam logic [hsc_pkg::HSC_STAT_W-1:0] StValid = hsc_pkg::ST_VALID;
  localparam logic [hsc_pkg::HSC_STAT_W-1:0] StEmpty = hsc_pkg::ST_EMPTY;

  a_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_valid_i == (status_i == StValid)))
    else $error("is_valid disagrees with status");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((status_i == StEmpty) == (trimmed_length_i == '0)))
    else $error("empty verdict disagrees with trimmed length");

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (trimmed_length_i <= hsc_pkg::HSC_SAT_MAX))
    else $error("trimmed length beyond saturation");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(trimmed_length_i)))
    else $error("stalled verdict changed");

endmodule

bind hostname_syntax_checker_core hsc_checker u_hsc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .is_valid_i       (out_o.is_valid),
  .trimmed_length_i (out_o.trimmed_length)
);

/* verif/tb.sv */
// self-checking testbench for the streaming host name syntax checker core
`timescale 1ns / 100ps

module tb;

  localparam int CLK_HALF     = 6;
  localparam int SETTLE_CYCLES = 8;
  // run limit, far above what all queued requests need even with 64% stalls
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int SEG_ITEMS    = 220;
  localparam int MAX_SHOWN    = 10;

  localparam logic [7:0] DOT_CHAR    = 8'h2E;
  localparam logic [7:0] HYPHEN_CHAR = 8'h2D;
  localparam logic [7:0] BLANK_CODES [8] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
                                             8'd32, 8'd133, 8'd160};

  typedef logic [7:0] byte_q_t[$];

  // one character request as the driver presents it
  typedef struct packed {
    logic [7:0] code;
    logic       has;
    logic       last;
  } char_req_t;

  // one verdict on a whole host name
  typedef struct packed {
    hsc_pkg::status_e status;
    logic             ok;
    logic [8:0]       len;
  } verdict_t;

  // clock, reset and config port
  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [0:0]                    cfg_idx_i;
  logic [hsc_pkg::HSC_CFG_W-1:0] cfg_wdata_i;

  hsc_in_if  in_bus ();
  hsc_out_if out_bus ();

  hostname_syntax_checker_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // stimulus and scoreboard bookkeeping
  char_req_t pending_reqs[$];
  verdict_t  verdicts_due[$];
  int        reqs_queued   = 0;
  int        reqs_taken    = 0;
  int        name_items    = 0;
  int        names_checked = 0;
  int        valid_seen    = 0;
  int        mismatches    = 0;
  int        cycle_count   = 0;
  logic [8:0] codes_seen   = '0;

  // idle percentages, changed between segments
  int send_idle_pct  = 30;
  int recv_stall_pct = 64;

  // predictor copy of the limit registers
  int lim_name  = int'(hsc_pkg::HSC_MAX_NAME_RST);
  int lim_label = int'(hsc_pkg::HSC_MAX_LABEL_RST);

  // predictor copy of the per-name state
  bit               nm_started    = 1'b0;
  int               nm_len        = 0;
  int               nm_spaces     = 0;
  bit               nm_lead_dot   = 1'b0;
  bit               nm_after_dot  = 1'b0;
  bit               nm_dot_pair   = 1'b0;
  int               lbl_len       = 0;
  bit               lbl_clean     = 1'b1;
  bit               lbl_end_alnum = 1'b0;
  hsc_pkg::status_e lbl_fault     = hsc_pkg::ST_VALID;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // counters stick at 256
  function automatic int clamp_count(input int v);
    return (v > 256) ? 256 : v;
  endfunction

  // the whitespace set that trimming removes
  function automatic bit is_blank(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'd133 || c == 8'd160;
  endfunction

  // ascii letters and digits only, latin-1 letters do not count
  function automatic bit is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // label ends at a dot or at the end; only the first faulty label is kept
  function automatic void shut_label();
    hsc_pkg::status_e f;
    f = hsc_pkg::ST_VALID;
    if (lbl_len == 0) begin
      f = hsc_pkg::ST_EMPTY_LABEL;
    end else if (lbl_len > lim_label) begin
      f = hsc_pkg::ST_LABEL_LONG;
    end else if (!lbl_clean || !lbl_end_alnum) begin
      f = hsc_pkg::ST_BAD_CHARS;
    end
    if (lbl_fault == hsc_pkg::ST_VALID) lbl_fault = f;
    lbl_len       = 0;
    lbl_clean     = 1'b1;
    lbl_end_alnum = 1'b0;
  endfunction

  function automatic void forget_name();
    nm_started    = 1'b0;
    nm_len        = 0;
    nm_spaces     = 0;
    nm_lead_dot   = 1'b0;
    nm_after_dot  = 1'b0;
    nm_dot_pair   = 1'b0;
    lbl_len       = 0;
    lbl_clean     = 1'b1;
    lbl_end_alnum = 1'b0;
    lbl_fault     = hsc_pkg::ST_VALID;
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    // whitespace is held back until a later non-blank proves it is inner
    if (is_blank(c)) begin
      if (nm_started) nm_spaces = clamp_count(nm_spaces + 1);
      return;
    end
    if (nm_spaces != 0) begin
      nm_len        = clamp_count(nm_len + nm_spaces);
      lbl_len       = clamp_count(lbl_len + nm_spaces);
      lbl_clean     = 1'b0;
      lbl_end_alnum = 1'b0;
      nm_after_dot  = 1'b0;
      nm_spaces     = 0;
    end
    nm_started = 1'b1;
    if (c == DOT_CHAR) begin
      if (nm_len == 0) nm_lead_dot = 1'b1;
      if (nm_after_dot) nm_dot_pair = 1'b1;
      nm_len = clamp_count(nm_len + 1);
      shut_label();
      nm_after_dot = 1'b1;
      return;
    end
    nm_len = clamp_count(nm_len + 1);
    if (lbl_len == 0 && !is_alnum(c)) lbl_clean = 1'b0;
    if (!is_alnum(c) && c != HYPHEN_CHAR) lbl_clean = 1'b0;
    lbl_end_alnum = is_alnum(c);
    lbl_len       = clamp_count(lbl_len + 1);
    nm_after_dot  = 1'b0;
  endfunction

  // returns 1 and the verdict when the request closes a name
  function automatic bit hostname_predict(input logic [7:0] c, input logic has,
                                          input logic last, output verdict_t v);
    hsc_pkg::status_e st;
    if (has) absorb_char(c);
    if (!last) return 1'b0;
    nm_spaces = 0;  // trailing blanks are dropped
    if (nm_len == 0) begin
      st = hsc_pkg::ST_EMPTY;
    end else begin
      shut_label();
      if (nm_len > lim_name)  st = hsc_pkg::ST_TOO_LONG;
      else if (nm_lead_dot)   st = hsc_pkg::ST_LEAD_DOT;
      else if (nm_after_dot)  st = hsc_pkg::ST_TRAIL_DOT;
      else if (nm_dot_pair)   st = hsc_pkg::ST_DOUBLE_DOT;
      else                    st = lbl_fault;
    end
    v.status = st;
    v.ok     = (st == hsc_pkg::ST_VALID);
    v.len    = 9'(nm_len);
    forget_name();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_req(input logic [7:0] code, input logic has,
                                    input logic last);
    pending_reqs.push_back('{code, has, last});
    reqs_queued++;
    if (has || last) name_items++;
  endfunction

  function automatic logic [7:0] pick_blank();
    return BLANK_CODES[$urandom_range(7)];
  endfunction

  // first and last positions of a label get a letter or digit only
  function automatic logic [7:0] pick_label_char(input bit at_end);
    int r;
    r = $urandom_range(at_end ? 61 : 68);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    if (r < 62) return 8'("a" + r - 36);
    return HYPHEN_CHAR;
  endfunction

  // wraps a body in blanks, sprinkles ignored fillers, closes on the last char
  // or with a bare end marker
  function automatic void send_name(input byte_q_t body, input int lead, input int trail,
                                    input bit bare_end);
    byte_q_t chars;
    repeat (lead) chars.push_back(pick_blank());
    chars = {chars, body};
    repeat (trail) chars.push_back(pick_blank());
    if (chars.size() == 0) bare_end = 1'b1;
    foreach (chars[i]) begin
      if ($urandom_range(19) == 0) queue_req(8'($urandom_range(255)), 1'b0, 1'b0);
      queue_req(chars[i], 1'b1, !bare_end && i == chars.size() - 1);
    end
    if (bare_end) queue_req(8'($urandom_range(255)), 1'b0, 1'b1);
  endfunction

  function automatic void send_text(input string s, input bit bare_end);
    byte_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    send_name(q, 0, 0, bare_end);
  endfunction

  // mostly well-formed names, the rest broken in one place or pure noise
  function automatic void push_random_name();
    byte_q_t body;
    int      n_labels;
    int      len;
    int      pos;
    n_labels = $urandom_range(1, 4);
    for (int l = 0; l < n_labels; l++) begin
      if (l != 0) body.push_back(DOT_CHAR);
      len = $urandom_range(1, (lim_label < 10) ? lim_label + 2 : 10);
      for (int k = 0; k < len; k++) body.push_back(pick_label_char(k == 0 || k == len - 1));
    end
    if ($urandom_range(99) >= 55) begin
      pos = $urandom_range(body.size() - 1);
      case ($urandom_range(7))
        0: body.push_front(DOT_CHAR);
        1: body.push_back(DOT_CHAR);
        2: begin
          body.insert(pos, DOT_CHAR);
          body.insert(pos, DOT_CHAR);
        end
        3: body.insert(pos, pick_blank());
        4: body[pos] = 8'($urandom_range(255));
        5: body[pos] = HYPHEN_CHAR;
        6: body.delete();
        default: begin
          body.delete();
          repeat ($urandom_range(1, 6)) body.push_back(8'($urandom_range(255)));
        end
      endcase
    end
    send_name(body, $urandom_range(2), $urandom_range(2), $urandom_range(5) == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // config writes and drain
  // ---------------------------------------------------------------------------

  task automatic write_limit(input hsc_pkg::cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hsc_pkg::REG_MAX_NAME) lim_name = int'(val);
    else                              lim_label = int'(val);
  endtask

  // every request taken, every verdict in, then let the back end go quiet
  task automatic settle();
    do @(posedge clk_i);
    while (reqs_taken != reqs_queued || verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void note_fault(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents the next pending request, holds it until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_chars
    char_req_t nxt;
    if (rst_ni && (!in_bus.valid || in_bus.ready)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.char_code <= nxt.code;
        in_bus.has_char  <= nxt.has;
        in_bus.is_last   <= nxt.last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_bus.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: checks verdicts first, then predicts from the request taken
  // at the same edge, so a fresh expectation never hides a stray verdict
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    verdict_t due;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (verdicts_due.size() == 0) begin
          note_fault($sformatf("verdict with none expected: status %0d valid %0b len %0d",
                               out_bus.status, out_bus.is_valid, out_bus.trimmed_length));
        end else begin
          due = verdicts_due.pop_front();
          names_checked++;
          if (due.ok) valid_seen++;
          codes_seen[due.status] = 1'b1;
          if (out_bus.status !== due.status || out_bus.is_valid !== due.ok ||
              out_bus.trimmed_length !== due.len) begin
            note_fault($sformatf(
              "name %0d: expected status %0d valid %0b len %0d, got status %0d valid %0b len %0d",
              names_checked, due.status, due.ok, due.len,
              out_bus.status, out_bus.is_valid, out_bus.trimmed_length));
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        reqs_taken++;
        if (hostname_predict(in_bus.char_code, in_bus.has_char, in_bus.is_last, due))
          verdicts_due.push_back(due);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d verdicts still due", cycle_count,
             verdicts_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    byte_q_t body;
    int      seg_start;
    int      seg_name [6];
    int      seg_label [6];

    // limits per segment: extremes, 20/4, the reset values and a random pair
    seg_name  = '{255, 1, 20, 255, 253, 0};
    seg_label = '{255, 255, 4, 1, 63, 0};

    // every input known from time zero
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = hsc_pkg::REG_MAX_NAME;
    cfg_wdata_i      = '0;
    in_bus.valid     = 1'b0;
    in_bus.char_code = '0;
    in_bus.has_char  = 1'b0;
    in_bus.is_last   = 1'b0;
    out_bus.ready    = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed names under the reset limits
    send_text("a", 1'b0);                          // plain valid
    send_text("", 1'b1);                           // bare end marker alone
    send_text(" \t", 1'b0);                        // only whitespace
    send_text(".a", 1'b0);                         // leading dot
    send_text("a.", 1'b0);                         // trailing dot
    send_text("a..b", 1'b0);                       // consecutive dots
    send_text("a b", 1'b0);                        // inner whitespace
    send_text("x-", 1'b0);                         // label ends in hyphen
    body = {8'hA0, 8'h39, 8'h85};
    send_name(body, 0, 0, 1'b0);                   // latin-1 blanks trimmed
    body = {8'hFF};
    send_name(body, 0, 0, 1'b0);                   // top byte
    body = {8'h5A, 8'h00};
    send_name(body, 0, 0, 1'b1);                   // zero byte, bare end
    queue_req(8'hFF, 1'b0, 1'b0);                  // ignored filler
    // leave a name open so the label limit changes under it
    queue_req(8'h61, 1'b1, 1'b0);
    queue_req(8'h62, 1'b1, 1'b0);

    for (int s = 0; s < 6; s++) begin
      settle();
      // sender 30 / receiver 64, then swapped, then no idling
      case (s / 2)
        0: begin
          send_idle_pct  = 30;
          recv_stall_pct = 64;
        end
        1: begin
          send_idle_pct  = 64;
          recv_stall_pct = 30;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_limit(hsc_pkg::REG_MAX_NAME,
                  8'((s == 5) ? $urandom_range(1, 255) : seg_name[s]));
      write_limit(hsc_pkg::REG_MAX_LABEL,
                  8'((s == 5) ? $urandom_range(1, 255) : seg_label[s]));
      seg_start = name_items;

      if (s == 0) begin
        // close the open name under the new label limit
        queue_req(8'h00, 1'b0, 1'b1);
        // one label of exactly the widest limit
        body.delete();
        for (int k = 0; k < 255; k++) body.push_back(pick_label_char(k == 0 || k == 254));
        send_name(body, 1, 1, 1'b0);
      end
      if (s == 4) begin
        // long inner blank run: every counter saturates
        body.delete();
        body.push_back(8'h61);
        repeat (260) body.push_back(pick_blank());
        body.push_back(8'h62);
        send_name(body, 0, 0, 1'b0);
      end
      while (name_items - seg_start < SEG_ITEMS) push_random_name();
    end
    settle();

    $display("covered %0d requests and %0d host name verdicts, %0d of them valid",
             reqs_taken, names_checked, valid_seen);
    $display("status codes reached (bit per code) %b, %0d mismatches", codes_seen, mismatches);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
